// ===== design/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge outside reset.
`define CPBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define CPBC_NEVER(lbl, cond, msg) \
  `CPBC_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/cpbc_pkg.sv =====
// Shared types, constants and helpers of the camera pixel to BGRA converter.
`default_nettype none

package cpbc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int FW_W          = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [FW_W-1:0] FW_RESET = 13'd640;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;

  typedef enum logic [1:0] {
    FMT_RGB32 = 2'd0,
    FMT_RGB24 = 2'd1,
    FMT_YUY2  = 2'd2,
    FMT_UYVY  = 2'd3
  } fmt_e;

  // Width of the signed color arithmetic.
  localparam int SW = 20;

  localparam logic [7:0]          LUMA_OFS   = 8'd16;
  localparam logic signed [SW-1:0] CHROMA_OFS = 20'sd128;
  localparam logic signed [SW-1:0] K_Y        = 20'sd298;
  localparam logic signed [SW-1:0] K_RV       = 20'sd409;
  localparam logic signed [SW-1:0] K_GU       = 20'sd100;
  localparam logic signed [SW-1:0] K_GV       = 20'sd208;
  localparam logic signed [SW-1:0] K_BU       = 20'sd516;
  localparam logic signed [SW-1:0] ROUND      = 20'sd128;
  localparam logic [7:0]          ALPHA_OPAQUE = 8'hFF;

  // One classified group: for RGB, y0/u/v carry blue/green/red.
  typedef struct packed {
    logic       rgb;
    logic       two;
    logic       eor0;
    logic       eor1;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] u;
    logic [7:0] v;
  } cpbc_entry_t;

  // Scale down by 256 and clamp to 0..255.
  function automatic logic [7:0] clamp_chan(input logic signed [SW-1:0] s);
    logic [7:0] r;
    if (s[SW-1]) begin
      r = '0;
    end else if (|s[SW-2:16]) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/cpbc_if.sv =====
// Stream interfaces: camera byte groups in, BGRA pixels out.
`default_nettype none

interface cpbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  input ready);
  modport sink   (input valid, input byte0, input byte1, input byte2, input byte3,
                  output ready);
endinterface

interface cpbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic       last_of_item;
  logic       end_of_row;

  modport source (output valid, output blue, output green, output red, output alpha,
                  output last_of_item, output end_of_row, input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha,
                  input last_of_item, input end_of_row, output ready);
endinterface

`default_nettype wire

// ===== design/cpbc_queue.sv =====
// Short queue of classified groups between front and back.
`default_nettype none
`include "assert_macros.svh"

module cpbc_queue
  import cpbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  cpbc_entry_t      push_data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output cpbc_entry_t      head_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cpbc_entry_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == NW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CPBC_NEVER(a_push_full, push_i && full_o, "push into full queue")
  `CPBC_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")
  `CPBC_NEVER(a_cnt_range, cnt_q > NW'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== design/cpbc_front.sv =====
// Front end: configuration registers, column tracking and group classification.
`default_nettype none

module cpbc_front
  import cpbc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FW_W-1:0]      cfg_data_i,
  cpbc_in_if.sink                   src_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output cpbc_entry_t               entry_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (NW > FW_W) ? NW : FW_W;
  localparam int XW = WW + 1;

  fmt_e            fmt_q, fmt_d;
  logic [FW_W-1:0] fw_q, fw_d;
  logic [CW-1:0]   col_q, col_d;

  logic [XW-1:0]   w_eff, col_base, col1, col2, col_nxt;
  logic            two;

  assign src_i.ready = !full_i;
  assign push_o      = src_i.valid && !full_i;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = XW'(1);
    end else if (XW'(fw_q) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(fw_q);
    end
    // restart a column left beyond a narrowed row
    col_base = (XW'(col_q) >= w_eff) ? '0 : XW'(col_q);
    col1     = col_base + XW'(1);
    col2     = col_base + XW'(2);
    two      = col1 < w_eff;
  end

  always_comb begin
    entry_o      = '0;
    entry_o.eor0 = (col1 == w_eff);
    entry_o.eor1 = (col2 == w_eff);
    col_nxt      = '0;
    case (fmt_q)
      FMT_RGB32, FMT_RGB24: begin
        entry_o.rgb = 1'b1;
        entry_o.y0  = src_i.byte0;
        entry_o.u   = src_i.byte1;
        entry_o.v   = src_i.byte2;
        col_nxt     = entry_o.eor0 ? '0 : col1;
      end
      FMT_YUY2: begin
        entry_o.two = two;
        entry_o.y0  = src_i.byte0;
        entry_o.u   = src_i.byte1;
        entry_o.y1  = src_i.byte2;
        entry_o.v   = src_i.byte3;
        col_nxt     = (two && !entry_o.eor1) ? col2 : '0;
      end
      FMT_UYVY: begin
        entry_o.two = two;
        entry_o.u   = src_i.byte0;
        entry_o.y0  = src_i.byte1;
        entry_o.v   = src_i.byte2;
        entry_o.y1  = src_i.byte3;
        col_nxt     = (two && !entry_o.eor1) ? col2 : '0;
      end
      default: begin
        col_nxt = '0;
      end
    endcase
  end

  always_comb begin
    fmt_d = fmt_q;
    fw_d  = fw_q;
    col_d = col_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PIXEL_FORMAT: fmt_d = fmt_e'(cfg_data_i[1:0]);
        REG_FRAME_WIDTH:  fw_d  = cfg_data_i;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
    if (push_o) begin
      col_d = col_nxt[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_YUY2;
      fw_q  <= FW_RESET;
      col_q <= '0;
    end else begin
      fmt_q <= fmt_d;
      fw_q  <= fw_d;
      col_q <= col_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/cpbc_back.sv =====
// Back end: per-pixel color conversion in two stages, the products and the output register.
`default_nettype none
`include "assert_macros.svh"

module cpbc_back
  import cpbc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     head_valid_i,
  input  cpbc_entry_t   head_i,
  output logic          pop_o,
  cpbc_out_if.source    dst_o
);

  logic sel_q, sel_d;
  logic en, issue;

  // stage 1: products
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_rgb_q, s1_last_q, s1_eor_q;
  logic [7:0]           s1_b_q, s1_g_q, s1_r_q;
  logic signed [SW-1:0] p_y_q, p_rv_q, p_gu_q, p_gv_q, p_bu_q;
  logic signed [SW-1:0] p_y_d, p_rv_d, p_gu_d, p_gv_d, p_bu_d;

  // stage 2: output register
  logic                 s2_valid_q, s2_valid_d;
  logic [7:0]           blue_q, green_q, red_q;
  logic [7:0]           blue_d, green_d, red_d;
  logic                 last_q, eor_q;

  logic [7:0]           y_sel, c_val;
  logic signed [SW-1:0] d_s, e_s;
  logic signed [SW-1:0] sum_r, sum_g, sum_b;

  assign en    = !s2_valid_q || dst_o.ready;
  assign issue = en && head_valid_i;
  // hold the head while its first pixel of two goes out
  assign pop_o = issue && !(head_i.two && !sel_q);
  assign sel_d = issue ? (head_i.two && !sel_q) : sel_q;

  assign s1_valid_d = en ? issue : s1_valid_q;
  assign s2_valid_d = en ? s1_valid_q : s2_valid_q;

  always_comb begin
    y_sel = sel_q ? head_i.y1 : head_i.y0;
    c_val = (y_sel > LUMA_OFS) ? y_sel - LUMA_OFS : '0;
    d_s   = $signed(SW'(head_i.u)) - CHROMA_OFS;
    e_s   = $signed(SW'(head_i.v)) - CHROMA_OFS;
    p_y_d  = $signed(SW'(c_val)) * K_Y;
    p_rv_d = e_s * K_RV;
    p_gu_d = d_s * K_GU;
    p_gv_d = e_s * K_GV;
    p_bu_d = d_s * K_BU;
  end

  always_comb begin
    sum_r = p_y_q + p_rv_q + ROUND;
    sum_g = p_y_q - p_gu_q - p_gv_q + ROUND;
    sum_b = p_y_q + p_bu_q + ROUND;
    if (s1_rgb_q) begin
      blue_d  = s1_b_q;
      green_d = s1_g_q;
      red_d   = s1_r_q;
    end else begin
      blue_d  = clamp_chan(sum_b);
      green_d = clamp_chan(sum_g);
      red_d   = clamp_chan(sum_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      sel_q      <= sel_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_rgb_q  <= head_i.rgb;
      s1_last_q <= !head_i.two || sel_q;
      s1_eor_q  <= sel_q ? head_i.eor1 : head_i.eor0;
      s1_b_q    <= head_i.y0;
      s1_g_q    <= head_i.u;
      s1_r_q    <= head_i.v;
      p_y_q     <= p_y_d;
      p_rv_q    <= p_rv_d;
      p_gu_q    <= p_gu_d;
      p_gv_q    <= p_gv_d;
      p_bu_q    <= p_bu_d;
    end
    if (en && s1_valid_q) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
      last_q  <= s1_last_q;
      eor_q   <= s1_eor_q;
    end
  end

  assign dst_o.valid        = s2_valid_q;
  assign dst_o.blue         = blue_q;
  assign dst_o.green        = green_q;
  assign dst_o.red          = red_q;
  assign dst_o.alpha        = ALPHA_OPAQUE;
  assign dst_o.last_of_item = last_q;
  assign dst_o.end_of_row   = eor_q;

  `CPBC_ASSERT(a_sel_head, sel_q |-> head_valid_i && head_i.two, "second pixel without pair")
  `CPBC_ASSERT(a_sel_clear, pop_o |=> !sel_q, "pixel select left set after pop")

endmodule

`default_nettype wire

// ===== design/camera_pixel_to_bgra_converter.sv =====
// Camera pixel stream to opaque BGRA converter, top level.
// Takes one byte group per request and gives opaque BGRA pixels. RGB32 and RGB24
// groups give one pixel each and are taken one per cycle while the output is ready.
// YUY2 and UYVY groups give up to two pixels through the integer BT.601 formula; the
// output register emits one pixel per cycle while ready, and a pair holds the queue
// head until both are issued. A two-entry queue separates classification and column
// tracking from the conversion stages; a group goes through it, the product stage and
// the output register, and with no stall a second pixel follows in the next cycle.
// No clearing pass after reset. Write the configuration registers only while idle.
`default_nettype none

module camera_pixel_to_bgra_converter
  import cpbc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FW_W-1:0]      cfg_data_i,
  cpbc_in_if.sink                   src_i,
  cpbc_out_if.source                dst_o
);

  logic        push, full, pop, head_valid;
  cpbc_entry_t push_data, head;

  cpbc_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .src_i     (src_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_data)
  );

  cpbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  cpbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .dst_o       (dst_o)
  );

endmodule

`default_nettype wire
